// File: sv/fss_pkg.sv
// package: shared types, codes and helpers of the frequency scan sequencer
package fss_pkg;

  localparam int SETTLE_MS = 500;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_REPORT  = 3'd1,
    CMD_SQUELCH = 3'd2,
    CMD_START   = 3'd3,
    CMD_PAUSE   = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TUNE   = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_BEGUN  = 2'd2,
    KIND_ENDED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_BEGIN_FREQ = 3'd0,
    REG_END_FREQ   = 3'd1,
    REG_STEP_SIZE  = 3'd2,
    REG_ALGORITHM  = 3'd3,
    REG_STEP_DELAY = 3'd4
  } reg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frequency;
    logic [7:0]  strength;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } bundle_t;

  // floor(h * 7 / 10), division by reciprocal 6554 / 2^16
  function automatic logic [7:0] decay(input logic [7:0] h);
    logic [10:0] p;
    logic [23:0] q;
    p = 11'(h) * 11'd7;
    q = 24'(p) * 24'd6554;
    return q[23:16];
  endfunction

endpackage

// File: sv/fss_engine.sv
// scan engine: configuration and scan state registers with single-pass item logic
module fss_engine
  import fss_pkg::*;
#(
  parameter int FREQ_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  cmd,
  input  logic [7:0]  val,
  input  logic        adv,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output bundle_t     bundle
);

  localparam int SUM_W = (FREQ_BITS > 32) ? FREQ_BITS + 1 : 33;

  logic [31:0]          begin_freq_r, end_freq_r, step_size_r;
  logic                 algorithm_r;
  logic [15:0]          step_delay_r;

  logic [FREQ_BITS-1:0] cur_r, cur_nxt;
  logic [7:0]           latest_r, latest_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic [7:0]           held_r, held_nxt;
  logic                 synced_r, synced_nxt;
  logic                 paused_r, paused_nxt;
  logic                 stepping_r, stepping_nxt;
  logic [15:0]          step_cnt_r, step_cnt_nxt;
  logic                 settling_r, settling_nxt;
  logic [9:0]           settle_cnt_r, settle_cnt_nxt;

  logic                 settle_hit, step_hit;
  logic [7:0]           lat_eff, step_held;
  logic [SUM_W-1:0]     sum;
  logic                 sum_end;
  logic [FREQ_BITS-1:0] cur_step;
  logic                 st_start, st_step;

  assign settle_hit = ({1'b0, settle_cnt_r} + 11'd1) >= 11'(SETTLE_MS);
  assign step_hit   = ({1'b0, step_cnt_r} + 17'd1) >= {1'b0, step_delay_r};

  // change-driven step sees the new reading as latest
  assign lat_eff   = (cmd_t'(cmd) == CMD_REPORT) ? val : latest_r;
  assign step_held = (prev_r == lat_eff) ? decay(held_r) : lat_eff;
  assign sum       = SUM_W'(cur_r) + SUM_W'(step_size_r);
  assign sum_end   = sum >= SUM_W'(end_freq_r);
  assign cur_step  = sum[FREQ_BITS-1:0];

  always_comb begin
    cur_nxt        = cur_r;
    latest_nxt     = latest_r;
    prev_nxt       = prev_r;
    held_nxt       = held_r;
    synced_nxt     = synced_r;
    paused_nxt     = paused_r;
    stepping_nxt   = stepping_r;
    step_cnt_nxt   = step_cnt_r;
    settling_nxt   = settling_r;
    settle_cnt_nxt = settle_cnt_r;
    st_start       = 1'b0;
    st_step        = 1'b0;
    bundle         = '0;

    unique case (cmd_t'(cmd))
      CMD_TICK: begin
        if (settling_r) begin
          if (settle_hit) begin
            settling_nxt   = 1'b0;
            settle_cnt_nxt = '0;
            st_start       = 1'b1;
          end else begin
            settle_cnt_nxt = settle_cnt_r + 10'd1;
          end
        end
        if (stepping_r && !st_start) begin
          if (step_hit) begin
            step_cnt_nxt = '0;
            st_step      = 1'b1;
          end else begin
            step_cnt_nxt = step_cnt_r + 16'd1;
          end
        end
      end
      CMD_REPORT: begin
        if (!algorithm_r) begin
          latest_nxt = val;
        end else if (stepping_r && latest_r != val) begin
          latest_nxt = val;
          st_step    = 1'b1;
        end
      end
      CMD_SQUELCH: begin
        if (val == 8'd0) latest_nxt = '0;
      end
      CMD_START: begin
        st_start = 1'b1;
      end
      CMD_PAUSE: begin
        paused_nxt = (val != 8'd0);
      end
      CMD_STOP: begin
        stepping_nxt   = 1'b0;
        settling_nxt   = 1'b0;
        step_cnt_nxt   = '0;
        settle_cnt_nxt = '0;
        synced_nxt     = 1'b0;
        paused_nxt     = 1'b0;
      end
      default: begin
      end
    endcase

    if (st_start) begin
      paused_nxt = 1'b0;
      bundle.cnt = 2'd1;
      if (synced_r) begin
        stepping_nxt = 1'b1;
        step_cnt_nxt = '0;
        bundle.r0    = '{kind: KIND_BEGUN, frequency: '0, strength: '0};
      end else begin
        bundle.r0      = '{kind: KIND_TUNE, frequency: begin_freq_r, strength: '0};
        cur_nxt        = FREQ_BITS'(begin_freq_r);
        latest_nxt     = '0;
        prev_nxt       = '0;
        held_nxt       = '0;
        synced_nxt     = 1'b1;
        settling_nxt   = 1'b1;
        settle_cnt_nxt = '0;
      end
    end

    if (st_step && !paused_r) begin
      held_nxt   = step_held;
      prev_nxt   = lat_eff;
      cur_nxt    = cur_step;
      bundle.cnt = 2'd2;
      bundle.r0  = '{kind: KIND_REPORT, frequency: 32'(cur_r), strength: step_held};
      if (sum_end) begin
        stepping_nxt = 1'b0;
        synced_nxt   = 1'b0;
        bundle.r1    = '{kind: KIND_ENDED, frequency: '0, strength: '0};
      end else begin
        bundle.r1    = '{kind: KIND_TUNE, frequency: 32'(cur_step), strength: '0};
      end
    end

    // change-driven step always re-arms the step timer
    if (st_step && cmd_t'(cmd) == CMD_REPORT) begin
      stepping_nxt = 1'b1;
      step_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_freq_r <= '0;
      end_freq_r   <= '0;
      step_size_r  <= 32'd1000;
      algorithm_r  <= 1'b0;
      step_delay_r <= 16'd500;
      cur_r        <= '0;
      latest_r     <= '0;
      prev_r       <= '0;
      held_r       <= '0;
      synced_r     <= 1'b0;
      paused_r     <= 1'b0;
      stepping_r   <= 1'b0;
      step_cnt_r   <= '0;
      settling_r   <= 1'b0;
      settle_cnt_r <= '0;
    end else begin
      if (adv) begin
        cur_r        <= cur_nxt;
        latest_r     <= latest_nxt;
        prev_r       <= prev_nxt;
        held_r       <= held_nxt;
        synced_r     <= synced_nxt;
        paused_r     <= paused_nxt;
        stepping_r   <= stepping_nxt;
        step_cnt_r   <= step_cnt_nxt;
        settling_r   <= settling_nxt;
        settle_cnt_r <= settle_cnt_nxt;
      end
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_idx))
          REG_BEGIN_FREQ: begin
            begin_freq_r <= cfg_wdata;
            cur_r        <= FREQ_BITS'(cfg_wdata);
          end
          REG_END_FREQ:   end_freq_r   <= cfg_wdata;
          REG_STEP_SIZE:  step_size_r  <= cfg_wdata;
          REG_ALGORITHM:  algorithm_r  <= cfg_wdata[0];
          REG_STEP_DELAY: step_delay_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: sv/fss_res_buf.sv
// result buffer: holds the results of one item and hands them out one per cycle while out_ready is high
module fss_res_buf
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bundle_t     bundle,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_frequency,
  output logic [7:0]  out_strength,
  output logic        out_last
);

  logic       b_valid_r;
  logic [1:0] b_cnt_r;
  logic       b_idx_r;
  res_t       b_res_r [2];
  res_t       cur_res;
  logic       done;

  assign cur_res       = b_res_r[b_idx_r];
  assign out_valid     = b_valid_r;
  assign out_kind      = cur_res.kind;
  assign out_frequency = cur_res.frequency;
  assign out_strength  = cur_res.strength;
  assign out_last      = ({1'b0, b_idx_r} + 2'd1) == b_cnt_r;
  assign done          = b_valid_r && out_ready && out_last;
  assign free          = !b_valid_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_cnt_r   <= '0;
      b_idx_r   <= 1'b0;
    end else begin
      if (load) begin
        b_valid_r <= 1'b1;
        b_cnt_r   <= bundle.cnt;
        b_idx_r   <= 1'b0;
      end else if (done) begin
        b_valid_r <= 1'b0;
      end else if (b_valid_r && out_ready) begin
        b_idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_res_r[0] <= bundle.r0;
      b_res_r[1] <= bundle.r1;
    end
  end

  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_cnt_r == 2'd1 || b_cnt_r == 2'd2))
    else $error("result count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result buffer loaded while busy");

  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_last))
    else $error("second result of an item missing");

endmodule

// File: sv/frequency_scan_sequencer.sv
// top level: receiver sweep controller with input register and result buffer
// path: an accepted item is held in the input register; its results are registered in the result buffer that drives out
// throughput: one item per cycle when it gives at most one result and out_ready is high;
// else the next item waits while the two-entry result buffer drains one result a cycle
// reset: synchronous active-low rst_n clears all control state, config takes its defaults
module frequency_scan_sequencer
  import fss_pkg::*;
#(
  parameter int FREQ_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_frequency,
  output logic [7:0]  out_strength,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic       a_valid_r;
  logic [2:0] a_cmd_r;
  logic [7:0] a_val_r;
  logic       a_adv;
  logic       buf_free;
  bundle_t    bundle;

  assign cfg_ready = 1'b1;
  assign a_adv     = a_valid_r && (bundle.cnt == 2'd0 || buf_free);
  assign in_ready  = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd_r <= in_command;
      a_val_r <= in_value;
    end
  end

  fss_engine #(
    .FREQ_BITS(FREQ_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (a_cmd_r),
    .val      (a_val_r),
    .adv      (a_adv),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_wdata(cfg_data),
    .bundle   (bundle)
  );

  fss_res_buf u_res_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (a_adv && bundle.cnt != 2'd0),
    .bundle       (bundle),
    .free         (buf_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_frequency(out_frequency),
    .out_strength (out_strength),
    .out_last     (out_last)
  );

endmodule
